// ===== hdl/dmc_pkg.sv =====
// Package for the direct-mapped cache model: geometry constants, request and
// register codes, line, counter and state types, saturating add.
// No dependencies.
`default_nettype none

package dmc_pkg;

  // Store geometry
  localparam int LINES      = 1024;
  localparam int LINE_BITS  = $clog2(LINES);
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = ADDR_W - 2;
  localparam int COUNT_W    = 32;
  localparam int CNT_W      = LINE_BITS + 1;
  localparam int WORDS_W    = 7;
  localparam int COPIED_W   = 17;
  localparam int BLK_MIN    = 2;
  localparam int BLK_MAX    = 8;

  // Request kinds
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_FETCH = 2'd2;
  localparam logic [1:0] REQ_FLUSH = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_SPLIT     = 3'd0;
  localparam logic [2:0] REG_WB        = 3'd1;
  localparam logic [2:0] REG_BLOCK     = 3'd2;
  localparam logic [2:0] REG_DATA_SIZE = 3'd3;
  localparam logic [2:0] REG_INS_SIZE  = 3'd4;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
  } line_t;

  typedef struct packed {
    count_t copy;
    count_t fetch;
    count_t repl;
    count_t miss;
    count_t acc;
  } counters_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_FLUSH_D,
    ST_FLUSH_I
  } state_t;

  // Add and saturate at the counter maximum
  function automatic count_t sat_add(count_t c, logic [COPIED_W-1:0] v);
    logic [COUNT_W:0] sum;
    sum = {1'b0, c} + (COUNT_W+1)'(v);
    return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/direct_mapped_cache_model.sv =====
// Direct-mapped cache model: tag stores, sweep for flush and reset clear,
// statistics counters, APB register block and output register.
// Depends on dmc_pkg.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser req_type, tdata address
//   m_axis    out  m_axis_tvalid/m_axis_tready  tuser stream, tlast, tdata results
//   apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A load, store or fetch reads the tag store at the accept edge, then compares and
// writes back the line in ST_UPDATE, which waits while the output register is full.
// A flush walks all 1024 lines of both stores, one line a cycle, and then
// emits two beats, the data stream and then the instruction stream.
// After reset the same walk clears both stores before s_axis_tready rises.
// A stalled output holds the next result back; the input side takes one item
// while a result still waits in the output register.
`default_nettype none

module direct_mapped_cache_model (
  input  wire logic         clk,
  input  wire logic         rst,
  // slave side
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // [31:0] address
  input  wire logic [1:0]   s_axis_tuser,   // [1:0] req_type
  // master side
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [191:0]      m_axis_tdata,   // [0] is_hit, [1] replaced,
                                            // [8:2] fetched_words, [25:9] copied_words,
                                            // [57:26] total_accesses, [89:58] total_misses,
                                            // [121:90] total_replacements,
                                            // [153:122] total_fetch_words,
                                            // [185:154] total_copy_words, rest zero
  output logic [0:0]        m_axis_tuser,   // [0] stream
  output logic              m_axis_tlast,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import dmc_pkg::*;

  // Configuration registers
  logic       split_mode;
  logic       write_back;
  logic [3:0] block_bytes_log2;
  logic [4:0] data_size_log2;
  logic [4:0] instr_size_log2;

  state_t state, state_next;

  // Tag stores
  line_t dmem [LINES];
  line_t imem [LINES];
  line_t d_rd_data, i_rd_data;

  // Request held for the update cycle
  logic [1:0]           req_q;
  logic [TAG_W-1:0]     tag_q;
  logic [LINE_BITS-1:0] idx_q;
  logic                 sel_instr_q;

  // Sweep
  logic [LINE_BITS-1:0] sweep_addr;
  logic                 sweep_rd_vld;
  logic [CNT_W-1:0]     dirty_cnt_d, dirty_cnt_i;

  counters_t cnt_d, cnt_i;

  // Output register
  logic                out_hit, out_repl, out_stream, out_last;
  logic [WORDS_W-1:0]  out_fetched;
  logic [COPIED_W-1:0] out_copied;
  counters_t           out_cnt;

  // Control
  logic                 in_go, out_free, out_load, sweeping;
  logic                 d_rd, i_rd, d_wr, i_wr;
  logic [LINE_BITS-1:0] rd_addr, wr_addr;
  line_t                wr_line;

  // ---------------- geometry ----------------
  logic [3:0]           blk;
  logic [2:0]           wshift;
  logic [WORDS_W-1:0]   words;
  logic [4:0]           size_sel, size_diff;
  logic [3:0]           ib;
  logic [LINE_BITS:0]   idx_mask;
  logic                 in_instr, in_sel_instr;
  logic [LINE_BITS-1:0] in_idx;
  logic [TAG_W-1:0]     in_tag;

  // Clamp block size, derive index width and split the address
  always_comb begin
    if (block_bytes_log2 < 4'(BLK_MIN)) begin
      blk = 4'(BLK_MIN);
    end else if (block_bytes_log2 > 4'(BLK_MAX)) begin
      blk = 4'(BLK_MAX);
    end else begin
      blk = block_bytes_log2;
    end
    wshift       = 3'(blk - 4'(BLK_MIN));
    words        = WORDS_W'(1) << wshift;
    in_instr     = (s_axis_tuser == REQ_FETCH);
    in_sel_instr = in_instr && split_mode;
    size_sel     = in_sel_instr ? instr_size_log2 : data_size_log2;
    size_diff    = (size_sel > 5'(blk)) ? (size_sel - 5'(blk)) : 5'd0;
    ib           = (size_diff > 5'(LINE_BITS)) ? 4'(LINE_BITS) : size_diff[3:0];
    idx_mask     = ((LINE_BITS+1)'(1) << ib) - (LINE_BITS+1)'(1);
    in_idx       = LINE_BITS'(s_axis_tdata >> blk) & idx_mask[LINE_BITS-1:0];
    in_tag       = TAG_W'(s_axis_tdata >> (5'(blk) + 5'(ib)));
  end

  // ---------------- lookup result ----------------
  line_t               cur;
  logic                is_store, hit, repl;
  logic [WORDS_W-1:0]  fetched;
  logic [COPIED_W-1:0] copied, flush_copied;
  line_t               new_line;
  counters_t           cnt_sel, cnt_upd, cnt_fl;

  // Compare tag and build the updated line and counters
  always_comb begin
    cur      = sel_instr_q ? i_rd_data : d_rd_data;
    is_store = (req_q == REQ_STORE);
    hit      = cur.valid && (cur.tag == tag_q);
    repl     = !hit && cur.valid;
    fetched  = hit ? '0 : words;
    copied   = '0;
    new_line = cur;
    if (hit) begin
      if (is_store && write_back) begin
        new_line.dirty = 1'b1;
      end else if (is_store) begin
        copied = COPIED_W'(words);
      end
    end else begin
      new_line.tag   = tag_q;
      new_line.valid = 1'b1;
      if (write_back) begin
        if (cur.dirty) begin
          copied = COPIED_W'(words);
        end
        new_line.dirty = is_store;
      end else begin
        if (is_store) begin
          copied = COPIED_W'(words);
        end
        new_line.dirty = 1'b0;
      end
    end
    cnt_sel       = (req_q == REQ_FETCH) ? cnt_i : cnt_d;
    cnt_upd.acc   = sat_add(cnt_sel.acc, COPIED_W'(1));
    cnt_upd.miss  = sat_add(cnt_sel.miss, COPIED_W'(!hit));
    cnt_upd.repl  = sat_add(cnt_sel.repl, COPIED_W'(repl));
    cnt_upd.fetch = sat_add(cnt_sel.fetch, COPIED_W'(fetched));
    cnt_upd.copy  = sat_add(cnt_sel.copy, copied);
    // Flush copy-back: one block per dirty line of the store being reported
    flush_copied  = COPIED_W'((state == ST_FLUSH_I) ? dirty_cnt_i : dirty_cnt_d) << wshift;
    cnt_fl        = (state == ST_FLUSH_I) ? cnt_i : cnt_d;
    cnt_fl.copy   = sat_add(cnt_fl.copy, flush_copied);
  end

  // ---------------- state machine ----------------
  always_comb begin
    in_go    = s_axis_tvalid && s_axis_tready;
    out_free = !m_axis_tvalid || m_axis_tready;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sweep_addr == {LINE_BITS{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_go) state_next = (s_axis_tuser == REQ_FLUSH) ? ST_SWEEP : ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sweep_addr == {LINE_BITS{1'b1}}) state_next = ST_SWEEP_END;
      end
      ST_SWEEP_END: state_next = ST_FLUSH_D;
      ST_FLUSH_D: begin
        if (out_free) state_next = ST_FLUSH_I;
      end
      ST_FLUSH_I: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    sweeping      = (state == ST_CLEAR) || (state == ST_SWEEP);
    out_load      = out_free && ((state == ST_UPDATE) || (state == ST_FLUSH_D) ||
                                 (state == ST_FLUSH_I));
    rd_addr       = sweeping ? sweep_addr : in_idx;
    d_rd          = sweeping || (in_go && (s_axis_tuser != REQ_FLUSH) && !in_sel_instr);
    i_rd          = sweeping || (in_go && (s_axis_tuser != REQ_FLUSH) && in_sel_instr);
    wr_addr       = sweeping ? sweep_addr : idx_q;
    wr_line       = sweeping ? line_t'('0) : new_line;
    d_wr          = sweeping || ((state == ST_UPDATE) && out_free && !sel_instr_q);
    i_wr          = sweeping || ((state == ST_UPDATE) && out_free && sel_instr_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- tag stores ----------------
  always_ff @(posedge clk) begin
    if (d_wr) dmem[wr_addr] <= wr_line;
    if (d_rd) d_rd_data <= dmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (i_wr) imem[wr_addr] <= wr_line;
    if (i_rd) i_rd_data <= imem[rd_addr];
  end

  // Hold the request for the update cycle
  always_ff @(posedge clk) begin
    if (in_go) begin
      req_q       <= s_axis_tuser;
      tag_q       <= in_tag;
      idx_q       <= in_idx;
      sel_instr_q <= in_sel_instr;
    end
  end

  // ---------------- sweep ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr   <= '0;
      sweep_rd_vld <= 1'b0;
      dirty_cnt_d  <= '0;
      dirty_cnt_i  <= '0;
    end else begin
      sweep_rd_vld <= (state == ST_SWEEP);
      if (sweeping) begin
        sweep_addr <= sweep_addr + LINE_BITS'(1);
      end
      if (in_go && (s_axis_tuser == REQ_FLUSH)) begin
        dirty_cnt_d <= '0;
        dirty_cnt_i <= '0;
      end else if (sweep_rd_vld) begin
        dirty_cnt_d <= dirty_cnt_d + CNT_W'(d_rd_data.dirty);
        dirty_cnt_i <= dirty_cnt_i + CNT_W'(i_rd_data.dirty);
      end
    end
  end

  // ---------------- statistics ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_d <= '0;
      cnt_i <= '0;
    end else if (out_load) begin
      if (state == ST_UPDATE) begin
        if (req_q == REQ_FETCH) cnt_i <= cnt_upd;
        else                    cnt_d <= cnt_upd;
      end else if (state == ST_FLUSH_I) begin
        cnt_i <= cnt_fl;
      end else begin
        cnt_d <= cnt_fl;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_UPDATE) begin
        out_hit     <= hit;
        out_repl    <= repl;
        out_fetched <= fetched;
        out_copied  <= copied;
        out_stream  <= (req_q == REQ_FETCH);
        out_last    <= 1'b1;
        out_cnt     <= cnt_upd;
      end else begin
        out_hit     <= 1'b0;
        out_repl    <= 1'b0;
        out_fetched <= '0;
        out_copied  <= flush_copied;
        out_stream  <= (state == ST_FLUSH_I);
        out_last    <= (state == ST_FLUSH_I);
        out_cnt     <= cnt_fl;
      end
    end
  end

  assign m_axis_tdata = {6'b0, out_cnt.copy, out_cnt.fetch, out_cnt.repl, out_cnt.miss,
                         out_cnt.acc, out_copied, out_fetched, out_repl, out_hit};
  assign m_axis_tuser = out_stream;
  assign m_axis_tlast = out_last;

  // ---------------- configuration ----------------
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode       <= 1'b0;
      write_back       <= 1'b1;
      block_bytes_log2 <= 4'd4;
      data_size_log2   <= 5'd13;
      instr_size_log2  <= 5'd13;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SPLIT:     split_mode       <= pwdata[0];
        REG_WB:        write_back       <= pwdata[0];
        REG_BLOCK:     block_bytes_log2 <= pwdata[3:0];
        REG_DATA_SIZE: data_size_log2   <= pwdata[4:0];
        REG_INS_SIZE:  instr_size_log2  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_SPLIT:     prdata = 32'(split_mode);
      REG_WB:        prdata = 32'(write_back);
      REG_BLOCK:     prdata = 32'(block_bytes_log2);
      REG_DATA_SIZE: prdata = 32'(data_size_log2);
      REG_INS_SIZE:  prdata = 32'(instr_size_log2);
      default:       prdata = '0;
    endcase
  end

  // ---------------- assertions ----------------
  // A hit neither fetches nor evicts
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[8:2] == '0) && !m_axis_tdata[1])
    else $error("hit result reports fetch or replacement");

  // An access goes straight to its update cycle
  a_acc_update: assert property (@(posedge clk) disable iff (rst)
    in_go && (s_axis_tuser != REQ_FLUSH) |=> state == ST_UPDATE)
    else $error("access not followed by update");

  // Only the first beat of a flush is not last, and it reports the data stream
  a_first_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tuser == 1'b0))
    else $error("non-last beat on instruction stream");

  // Access counters never fall
  a_acc_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt_d.acc >= $past(cnt_d.acc)) && (cnt_i.acc >= $past(cnt_i.acc)))
    else $error("access counter decreased");

  // Dirty counts stay within the store size
  a_dirty_bound: assert property (@(posedge clk) disable iff (rst)
    (dirty_cnt_d <= CNT_W'(LINES)) && (dirty_cnt_i <= CNT_W'(LINES)))
    else $error("dirty count beyond store size");

endmodule

`default_nettype wire

// ===== tb/sv/tb_direct_mapped_cache_model.sv =====
// Self-checking testbench for the direct-mapped cache model: drives stream
// requests and register writes, predicts every result beat and compares them.
// Depends on dmc_pkg and direct_mapped_cache_model.
`timescale 1ns / 100ps

module tb_direct_mapped_cache_model;
  import dmc_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int SEGMENTS    = 8;
  localparam int CHUNK_ITEMS = 117;

  // Statistics counter slots
  localparam int STAT_ACC   = 0;
  localparam int STAT_MISS  = 1;
  localparam int STAT_REPL  = 2;
  localparam int STAT_FETCH = 3;
  localparam int STAT_COPY  = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
  } cache_req_t;

  typedef struct packed {
    logic                hit;
    logic                replaced;
    logic [WORDS_W-1:0]  fetched;
    logic [COPIED_W-1:0] copied;
    logic                stream;
    logic                last;
    logic [31:0]         acc;
    logic [31:0]         miss;
    logic [31:0]         repl;
    logic [31:0]         fetch;
    logic [31:0]         copy;
  } cache_result_t;

  typedef struct packed {
    logic       split;
    logic       wb;
    logic [3:0] blk;
    logic [4:0] dsize;
    logic [4:0] isize;
  } cache_setting_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // [31:0] address
  logic [1:0]   s_axis_tuser = '0;   // [1:0] req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;        // [0] is_hit, [1] replaced, [8:2] fetched_words,
                                     // [25:9] copied_words, [57:26] total_accesses,
                                     // [89:58] total_misses, [121:90] total_replacements,
                                     // [153:122] total_fetch_words,
                                     // [185:154] total_copy_words
  logic [0:0]   m_axis_tuser;        // [0] stream
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  direct_mapped_cache_model uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow registers, line state and statistics of the predictor
  logic        cfg_split = 1'b0;
  logic        cfg_wb    = 1'b1;
  logic [3:0]  cfg_block = 4'd4;
  logic [4:0]  cfg_dsize = 5'd13;
  logic [4:0]  cfg_isize = 5'd13;
  logic [31:0] line_tag   [2][LINES];
  logic        line_valid [2][LINES];
  logic        line_dirty [2][LINES];
  logic [31:0] stat_cnt   [2][5];

  cache_req_t    req_backlog[$];
  cache_result_t awaited_results[$];
  cache_req_t    beat_on_bus;
  logic          bus_loaded = 1'b0;
  cache_result_t seen;
  logic [31:0]   recent_addr [16];
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  int            err_count = 0;
  int            cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] c, int unsigned v);
    logic [32:0] sum;
    sum = {1'b0, c} + 33'(v);
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Count dirty lines of one store and invalidate all of them
  function automatic int unsigned sweep_store(int which);
    int unsigned n;
    n = 0;
    for (int i = 0; i < LINES; i++) begin
      if (line_dirty[which][i]) n++;
      line_valid[which][i] = 1'b0;
      line_dirty[which][i] = 1'b0;
    end
    return n;
  endfunction

  function automatic void load_stats(inout cache_result_t r, input int st);
    r.acc   = stat_cnt[st][STAT_ACC];
    r.miss  = stat_cnt[st][STAT_MISS];
    r.repl  = stat_cnt[st][STAT_REPL];
    r.fetch = stat_cnt[st][STAT_FETCH];
    r.copy  = stat_cnt[st][STAT_COPY];
  endfunction

  // Work out the result beats of one accepted request
  function automatic void predict_lookup(logic [1:0] kind, logic [31:0] addr);
    int            blk, words, st, sel, sz, ib, idx;
    int unsigned   moved;
    logic [31:0]   tag;
    cache_result_t r;
    blk = (cfg_block < BLK_MIN) ? BLK_MIN : ((cfg_block > BLK_MAX) ? BLK_MAX : int'(cfg_block));
    words = 1 << (blk - 2);
    if (kind == REQ_FLUSH) begin
      // data stream first, then the instruction stream closes the item
      for (st = 0; st < 2; st++) begin
        r = '0;
        moved = sweep_store(st) * words;
        stat_cnt[st][STAT_COPY] = sat_inc(stat_cnt[st][STAT_COPY], moved);
        r.copied = (moved > 32'h1FFFF) ? 17'h1FFFF : moved[COPIED_W-1:0];
        r.stream = (st == 1);
        r.last   = (st == 1);
        load_stats(r, st);
        awaited_results.push_back(r);
      end
      return;
    end
    // counters follow the request kind, lines follow the split setting
    st  = (kind == REQ_FETCH) ? 1 : 0;
    sel = (st == 1 && cfg_split) ? 1 : 0;
    sz  = sel ? int'(cfg_isize) : int'(cfg_dsize);
    ib  = (sz > blk) ? sz - blk : 0;
    if (ib > LINE_BITS) ib = LINE_BITS;
    idx = (addr >> blk) & ((1 << ib) - 1);
    tag = addr >> (blk + ib);
    r = '0;
    r.stream = (st == 1);
    r.last   = 1'b1;
    stat_cnt[st][STAT_ACC] = sat_inc(stat_cnt[st][STAT_ACC], 1);
    r.hit = line_valid[sel][idx] && (line_tag[sel][idx] == tag);
    if (r.hit) begin
      if (kind == REQ_STORE) begin
        if (cfg_wb) line_dirty[sel][idx] = 1'b1;
        else r.copied = COPIED_W'(words);
      end
    end else begin
      r.fetched = WORDS_W'(words);
      stat_cnt[st][STAT_MISS]  = sat_inc(stat_cnt[st][STAT_MISS], 1);
      stat_cnt[st][STAT_FETCH] = sat_inc(stat_cnt[st][STAT_FETCH], words);
      if (line_valid[sel][idx]) begin
        r.replaced = 1'b1;
        stat_cnt[st][STAT_REPL] = sat_inc(stat_cnt[st][STAT_REPL], 1);
      end
      if (cfg_wb) begin
        if (line_dirty[sel][idx]) r.copied = COPIED_W'(words);
        line_dirty[sel][idx] = (kind == REQ_STORE);
      end else begin
        if (kind == REQ_STORE) r.copied = COPIED_W'(words);
        line_dirty[sel][idx] = 1'b0;
      end
      line_valid[sel][idx] = 1'b1;
      line_tag[sel][idx]   = tag;
    end
    stat_cnt[st][STAT_COPY] = sat_inc(stat_cnt[st][STAT_COPY], r.copied);
    load_stats(r, st);
    awaited_results.push_back(r);
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Request driver: predict on each accepted beat, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_lookup(beat_on_bus.kind, beat_on_bus.addr);
        bus_loaded = 1'b0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          beat_on_bus = req_backlog.pop_front();
          bus_loaded = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= beat_on_bus.addr;
          s_axis_tuser  <= beat_on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          err_count++;
        end else begin
          seen.hit      = m_axis_tdata[0];
          seen.replaced = m_axis_tdata[1];
          seen.fetched  = m_axis_tdata[8:2];
          seen.copied   = m_axis_tdata[25:9];
          seen.acc      = m_axis_tdata[57:26];
          seen.miss     = m_axis_tdata[89:58];
          seen.repl     = m_axis_tdata[121:90];
          seen.fetch    = m_axis_tdata[153:122];
          seen.copy     = m_axis_tdata[185:154];
          seen.stream   = m_axis_tuser[0];
          seen.last     = m_axis_tlast;
          check_field("is_hit", awaited_results[0].hit, seen.hit);
          check_field("replaced", awaited_results[0].replaced, seen.replaced);
          check_field("fetched_words", awaited_results[0].fetched, seen.fetched);
          check_field("copied_words", awaited_results[0].copied, seen.copied);
          check_field("stream", awaited_results[0].stream, seen.stream);
          check_field("last", awaited_results[0].last, seen.last);
          check_field("total_accesses", awaited_results[0].acc, seen.acc);
          check_field("total_misses", awaited_results[0].miss, seen.miss);
          check_field("total_replacements", awaited_results[0].repl, seen.repl);
          check_field("total_fetch_words", awaited_results[0].fetch, seen.fetch);
          check_field("total_copy_words", awaited_results[0].copy, seen.copy);
          void'(awaited_results.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] kind, logic [31:0] addr);
    req_backlog.push_back('{kind: kind, addr: addr});
  endtask

  // Random requests: mostly reuse or near-miss of recent addresses
  task automatic queue_random(int n);
    int unsigned  pick;
    logic [1:0]   kind;
    logic [31:0]  addr;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(999);
      if (pick < 8) kind = REQ_FLUSH;
      else if (pick < 408) kind = REQ_LOAD;
      else if (pick < 708) kind = REQ_STORE;
      else kind = REQ_FETCH;
      pick = $urandom_range(99);
      if (pick < 45) addr = recent_addr[$urandom_range(15)] ^ 32'($urandom_range(3));
      else if (pick < 70) addr = recent_addr[$urandom_range(15)] ^ (32'd1 << $urandom_range(31));
      else addr = $urandom;
      recent_addr[$urandom_range(15)] = addr;
      push_req(kind, addr);
    end
  endtask

  // Hold until every request is accepted and every result has arrived
  task automatic drain_block();
    while (req_backlog.size() != 0 || bus_loaded || awaited_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SPLIT:     cfg_split = val[0];
      REG_WB:        cfg_wb    = val[0];
      REG_BLOCK:     cfg_block = val[3:0];
      REG_DATA_SIZE: cfg_dsize = val[4:0];
      REG_INS_SIZE:  cfg_isize = val[4:0];
      default: ;
    endcase
  endtask

  initial begin
    cache_setting_t setting [SEGMENTS];
    // extremes of every register, out-of-range block sizes among them
    setting[0] = '{split: 1'b1, wb: 1'b1, blk: 4'd2,  dsize: 5'd4,  isize: 5'd18};
    setting[1] = '{split: 1'b1, wb: 1'b0, blk: 4'd8,  dsize: 5'd18, isize: 5'd4};
    setting[2] = '{split: 1'b0, wb: 1'b0, blk: 4'd0,  dsize: 5'd31, isize: 5'd0};
    setting[3] = '{split: 1'b1, wb: 1'b1, blk: 4'd15, dsize: 5'd10, isize: 5'd12};
    setting[4] = '{split: 1'b0, wb: 1'b1, blk: 4'd9,  dsize: 5'd0,  isize: 5'd31};
    setting[5] = '{split: 1'b1, wb: 1'b0, blk: 4'd3,  dsize: 5'd7,  isize: 5'd9};
    setting[6] = '{split: 1'b1, wb: 1'b1, blk: 4'd4,  dsize: 5'd13, isize: 5'd13};
    setting[7] = '{split: 1'b0, wb: 1'b1, blk: 4'd5,  dsize: 5'd14, isize: 5'd6};

    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < LINES; i++) begin
        line_tag[s][i]   = '0;
        line_valid[s][i] = 1'b0;
        line_dirty[s][i] = 1'b0;
      end
      for (int c = 0; c < 5; c++) stat_cnt[s][c] = '0;
    end
    for (int i = 0; i < 16; i++) recent_addr[i] = $urandom;

    // Hold reset, then wait for the clearing sweep to finish
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);

    // Directed requests at the reset geometry
    src_idle_pct = 31;
    snk_idle_pct = 49;
    push_req(REQ_LOAD,  32'h0000_0000);
    push_req(REQ_LOAD,  32'h0000_000C);
    push_req(REQ_STORE, 32'h0000_0004);
    push_req(REQ_LOAD,  32'h0000_2000);
    push_req(REQ_STORE, 32'h0000_4008);
    push_req(REQ_STORE, 32'hFFFF_FFFF);
    push_req(REQ_FETCH, 32'hFFFF_FFF0);
    push_req(REQ_FETCH, 32'h8000_0000);
    push_req(REQ_LOAD,  32'h7FFF_FFFC);
    push_req(REQ_STORE, 32'h0000_6000);
    push_req(REQ_FLUSH, 32'hFFFF_FFFF);
    push_req(REQ_LOAD,  32'h0000_0000);
    push_req(REQ_FLUSH, 32'h0000_0000);
    push_req(REQ_FETCH, 32'h5555_5554);
    push_req(REQ_STORE, 32'hAAAA_AAA8);
    push_req(REQ_STORE, 32'h5555_5554);
    push_req(REQ_LOAD,  32'hAAAA_AAA8);
    drain_block();

    // Random segments, one geometry each, with a full drain half way through
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      src_idle_pct = (seg < 3) ? 31 : ((seg < 6) ? 49 : 0);
      snk_idle_pct = (seg < 3) ? 49 : ((seg < 6) ? 31 : 0);
      write_reg(REG_SPLIT,     32'(setting[seg].split));
      write_reg(REG_WB,        32'(setting[seg].wb));
      write_reg(REG_BLOCK,     32'(setting[seg].blk));
      write_reg(REG_DATA_SIZE, 32'(setting[seg].dsize));
      write_reg(REG_INS_SIZE,  32'(setting[seg].isize));
      queue_random(CHUNK_ITEMS);
      push_req(REQ_FLUSH, $urandom);
      drain_block();
      queue_random(CHUNK_ITEMS);
      drain_block();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
